@@ rtl/hbwd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbwd_pkg
// shared types and constants of the heartbeat watchdog
// ----------------------------------------------------------------------------
package hbwd_pkg;

   localparam int CHANNELS = 16;
   localparam int CH_W     = 4;
   localparam int CNT_W    = 5;
   localparam int SEQ_W    = 24;
   localparam int AGE_W    = 16;
   localparam int TYPE_W   = 8;
   localparam int CSR_W    = 16;

   // request payload: channel, sequence, message type (padded to bytes)
   localparam int REQ_BITS = CH_W + SEQ_W + TYPE_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   // response payload: channel, matched, gap, expected sequence, echoed type
   localparam int RSP_BITS = CH_W + 1 + 1 + SEQ_W + TYPE_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [AGE_W-1:0]  AGE_MAX       = {AGE_W{1'b1}};
   localparam logic [AGE_W-1:0]  TIMEOUT_RESET = AGE_W'(10);
   localparam logic [CNT_W-1:0]  CHAN_RESET    = CNT_W'(16);
   localparam logic [CNT_W-1:0]  CHAN_MAX      = CNT_W'(CHANNELS);
   localparam logic [TYPE_W-1:0] TYPE_NONE     = '0;

   // register indexes
   localparam logic CSR_TIMEOUT  = 1'b0;
   localparam logic CSR_CHANNELS = 1'b1;

   // item and report kinds
   localparam logic KIND_BEAT = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic capture;
      logic hb_commit;
      logic scan_step;
      logic flush;
   } hbwd_cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_end;
      logic step_blocked;
      logic pend_valid;
   } hbwd_status_type;

endpackage

@@ rtl/hbwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbwd_ctrl
// sequencer for heartbeat checks and tick scans
// ----------------------------------------------------------------------------
module hbwd_ctrl import hbwd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            req_tuser,
   input  hbwd_status_type status,
   output hbwd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BEAT  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_tuser == KIND_TICK) ? ST_SCAN : ST_BEAT;
            end
         end
         ST_BEAT: begin
            if (status.out_free) begin
               cmd.hb_commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               if (!status.pend_valid) begin
                  state_in = ST_IDLE;
               end else if (status.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (!status.step_blocked || status.out_free) begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/hbwd_dpath.sv @@
// ----------------------------------------------------------------------------
// hbwd_dpath
// channel state, config registers, scan pointer and response register
// ----------------------------------------------------------------------------
module hbwd_dpath import hbwd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  hbwd_cmd_type     cmd,
   output hbwd_status_type  status,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   logic [AGE_W-1:0]  timeout_ff;
   logic [CNT_W-1:0]  chan_cfg_ff;
   logic [CH_W-1:0]   in_ch_ff;
   logic [SEQ_W-1:0]  in_seq_ff;
   logic [TYPE_W-1:0] in_type_ff;
   logic [SEQ_W-1:0]  seq_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] known_ff;
   logic [AGE_W-1:0]  age_ff [CHANNELS];
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CH_W-1:0]   pend_ch_ff, pend_ch_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [CH_W-1:0]   rsp_ch_ff;
   logic              rsp_match_ff;
   logic              rsp_gap_ff;
   logic [SEQ_W-1:0]  rsp_exp_ff;
   logic [TYPE_W-1:0] rsp_type_ff;
   logic              rsp_last_ff;

   logic [CNT_W-1:0]  act_cnt;
   logic              hb_active;
   logic              hb_known;
   logic [SEQ_W-1:0]  hb_expect;
   logic [CH_W-1:0]   scan_ch;
   logic [AGE_W-1:0]  age_cur;
   logic [AGE_W-1:0]  age_inc;
   logic              expire;
   logic              out_free;
   logic              out_load;
   logic              load_beat;
   logic              load_last;

   assign act_cnt   = (chan_cfg_ff > CHAN_MAX) ? CHAN_MAX : chan_cfg_ff;
   assign hb_active = {1'b0, in_ch_ff} < act_cnt;
   assign hb_known  = hb_active && known_ff[in_ch_ff];
   assign hb_expect = seq_mem_ff[in_ch_ff] + SEQ_W'(1);

   assign scan_ch = idx_ff[CH_W-1:0];
   assign age_cur = age_ff[scan_ch];
   assign age_inc = (age_cur == AGE_MAX) ? age_cur : age_cur + AGE_W'(1);
   assign expire  = age_inc > timeout_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load_beat = cmd.hb_commit;
   assign load_last = cmd.hb_commit || cmd.flush;
   assign out_load  = cmd.hb_commit || cmd.flush || (cmd.scan_step && expire && pend_valid_ff);

   assign status.out_free     = out_free;
   assign status.scan_end     = idx_ff >= act_cnt;
   assign status.step_blocked = expire && pend_valid_ff;
   assign status.pend_valid   = pend_valid_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         chan_cfg_ff <= CHAN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata[AGE_W-1:0];
            CSR_CHANNELS: chan_cfg_ff <= csr_wdata[CNT_W-1:0];
            default:      ;
         endcase
      end
   end

   // captured request payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ch_ff   <= req_tdata[CH_W-1:0];
         in_seq_ff  <= req_tdata[CH_W +: SEQ_W];
         in_type_ff <= req_tdata[CH_W+SEQ_W +: TYPE_W];
      end
   end

   // last sequence store, written only on an accepted heartbeat
   always_ff @(posedge clock) begin
      if (cmd.hb_commit && hb_active) begin
         seq_mem_ff[in_ch_ff] <= in_seq_ff;
      end
   end

   // ages and known flags
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.hb_commit && hb_active) begin
         known_ff[in_ch_ff] <= 1'b1;
         age_ff[in_ch_ff]   <= '0;
      end else if (cmd.scan_step) begin
         if (expire) begin
            known_ff[scan_ch] <= 1'b0;
            age_ff[scan_ch]   <= '0;
         end else begin
            age_ff[scan_ch]   <= age_inc;
         end
      end
   end

   // scan pointer and the held-back timeout report
   always_comb begin
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      if (cmd.capture) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (expire) begin
            pend_valid_in = 1'b1;
            pend_ch_in    = scan_ch;
         end
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_ch_ff <= pend_ch_in;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_last_ff <= load_last;
         if (load_beat) begin
            rsp_kind_ff  <= KIND_BEAT;
            rsp_ch_ff    <= in_ch_ff;
            rsp_match_ff <= hb_active;
            rsp_gap_ff   <= hb_known && (in_seq_ff != hb_expect);
            rsp_exp_ff   <= hb_known ? hb_expect : '0;
            rsp_type_ff  <= in_type_ff;
         end else begin
            rsp_kind_ff  <= KIND_TICK;
            rsp_ch_ff    <= pend_ch_ff;
            rsp_match_ff <= 1'b0;
            rsp_gap_ff   <= 1'b0;
            rsp_exp_ff   <= '0;
            rsp_type_ff  <= TYPE_NONE;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_type_ff, rsp_exp_ff, rsp_gap_ff, rsp_match_ff, rsp_ch_ff});

endmodule

@@ rtl/multi_channel_heartbeat_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit
// supervises up to sixteen heartbeat sources: sequence checks and timeouts
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                   framing
//   req_      in    tuser kind, tdata channel/seq/type        one transfer per item
//   rsp_      out   tuser report kind, tdata report fields    tlast on final report
//   csr_      in    index 0 timeout, index 1 channel count    write only
//
// a heartbeat is loaded into the response register from the beat state once
// that register is free, and the unit takes no new item until it is back idle
// a tick walks the active channels one per cycle while no due report waits on
// a stalled response, then flushes any held-back report before the next item
// each timeout report is held back until the next expiring channel or the end
// of the scan, so the final one can carry tlast
// a stalled response stalls the scan only when a further report is due
// reset clears ages, known flags and the control state, and sets config to its defaults
//
module multi_channel_heartbeat_watchdog_unit import hbwd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // channel, sequence_req, message_type
   input  logic             req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // report_channel, matched, sequence_gap,
                                         // expected_sequence, echoed_type
   output logic             rsp_tuser,   // report_kind
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   hbwd_cmd_type    cmd;
   hbwd_status_type status;

   hbwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   hbwd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // one item at a time: busy straight after an accepted transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while still busy");

   // heartbeat reports are always the only report of their item
   a_beat_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_BEAT) |-> rsp_tlast)
      else $error("heartbeat report without tlast");

   // timeout reports carry no match, no gap and no echoed type
   a_timeout_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TICK) |-> (rsp_tdata[5:4] == 2'b00) &&
      (rsp_tdata[RSP_BITS-1:CH_W+2] == '0))
      else $error("timeout report with payload set");

   // an unmatched heartbeat never flags a gap
   a_no_gap_unmatched: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> !rsp_tdata[5])
      else $error("sequence gap on unmatched report");
`endif

endmodule
